### rtl/ubwt_pkg.sv
`timescale 1ns / 1ps

package ubwt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;

    localparam int KEY_W      = 13;
    localparam int COST_W     = 30;
    localparam int BW_W       = 32;
    localparam int MPS_W      = 10;
    localparam int BYTES_W    = 16;
    localparam int SLOT_W_MAX = 8;
    localparam int SLOT_OUT_W = 5;

    // Packet count width: the rounded-up dividend needs one bit more than the byte count.
    localparam int DIV_W  = BYTES_W + 1;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int FACT_W = MPS_W + 1;
    localparam int ACC_W  = 27;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    localparam logic [1:0] SPEED_LOW  = 2'd0;
    localparam logic [1:0] SPEED_FULL = 2'd1;

    localparam logic [1:0] KIND_ISOCHRONOUS = 2'd1;

    localparam logic [3:0] OVERHEAD_STD  = 4'd13;
    localparam logic [3:0] OVERHEAD_ISO  = 4'd9;
    localparam int         LOW_SPEED_SHIFT = 3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_ZEROPKT  = 3'd5;

    typedef struct packed {
        logic [1:0]         command;
        logic [6:0]         device_address;
        logic [3:0]         endpoint_number;
        logic [1:0]         transfer_direction;
        logic [1:0]         bus_speed;
        logic [1:0]         transfer_kind;
        logic [MPS_W-1:0]   packet_size_max;
        logic [BYTES_W-1:0] transfer_bytes;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [COST_W-1:0]     bandwidth_cost;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [BW_W-1:0]       free_bandwidth;
    } rsp_word_t;

    typedef struct packed {
        logic                  set;
        logic                  clear;
        logic [SLOT_W_MAX-1:0] slot;
        logic [KEY_W-1:0]      key;
        logic [COST_W-1:0]     cost;
    } ubwt_tbl_wr_t;

    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [SLOT_W_MAX-1:0] hit_slot;
        logic [COST_W-1:0]     hit_cost;
        logic                  vacant;
        logic [SLOT_W_MAX-1:0] vacant_slot;
    } ubwt_scan_res_t;

endpackage

### rtl/ubwt_cost.sv
`timescale 1ns / 1ps

module ubwt_cost
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    bus_speed,
    input  logic [1:0]                    transfer_kind,
    input  logic [ubwt_pkg::MPS_W-1:0]    packet_size_max,
    input  logic [ubwt_pkg::BYTES_W-1:0]  transfer_bytes,
    output logic [ubwt_pkg::COST_W-1:0]   cost,
    output logic                          done
);
    import ubwt_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DIV,
        C_MUL,
        C_SCALE
    } state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIV_W-1:0]   dq_reg;
    logic [MPS_W-1:0]   rem_reg;
    logic [MPS_W-1:0]   mps_reg;
    logic [FACT_W-1:0]  factor_reg;
    logic [1:0]         speed_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               done_reg;

    logic [3:0]         overhead;
    logic [MPS_W:0]     trial;
    logic [MPS_W:0]     diff;
    logic               fits;
    logic [ACC_W-1:0]   addend;
    logic               last_step;

    assign overhead  = (bus_speed == SPEED_FULL && transfer_kind == KIND_ISOCHRONOUS)
                       ? OVERHEAD_ISO : OVERHEAD_STD;
    assign trial     = {rem_reg, dq_reg[DIV_W-1]};
    assign diff      = trial - {1'b0, mps_reg};
    assign fits      = (trial >= {1'b0, mps_reg});
    assign addend    = dq_reg[DIV_W-1] ? ACC_W'(factor_reg) : '0;
    assign last_step = (step_reg == STEP_W'(DIV_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            step_reg   <= '0;
            dq_reg     <= '0;
            rem_reg    <= '0;
            mps_reg    <= '0;
            factor_reg <= '0;
            speed_reg  <= '0;
            acc_reg    <= '0;
            cost_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        dq_reg     <= DIV_W'(transfer_bytes) + DIV_W'(packet_size_max)
                                      - DIV_W'(1);
                        rem_reg    <= '0;
                        mps_reg    <= packet_size_max;
                        factor_reg <= FACT_W'(overhead) + FACT_W'(packet_size_max);
                        speed_reg  <= bus_speed;
                        step_reg   <= '0;
                        done_reg   <= 1'b0;
                        state_reg  <= C_DIV;
                    end
                end
                C_DIV:
                begin
                    rem_reg  <= fits ? diff[MPS_W-1:0] : trial[MPS_W-1:0];
                    dq_reg   <= {dq_reg[DIV_W-2:0], fits};
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        acc_reg   <= '0;
                        state_reg <= C_MUL;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                C_MUL:
                begin
                    acc_reg  <= {acc_reg[ACC_W-2:0], 1'b0} + addend;
                    dq_reg   <= {dq_reg[DIV_W-2:0], 1'b0};
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= C_SCALE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                C_SCALE:
                begin
                    if (speed_reg == SPEED_LOW)
                    begin
                        cost_reg <= {acc_reg, LOW_SPEED_SHIFT'(0)};
                    end
                    else if (speed_reg == SPEED_FULL)
                    begin
                        cost_reg <= COST_W'(acc_reg);
                    end
                    else
                    begin
                        cost_reg <= '0;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign cost = cost_reg;
    assign done = done_reg;

endmodule

### rtl/ubwt_scan.sv
`timescale 1ns / 1ps

module ubwt_scan
#(
    parameter int ENTRIES = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ubwt_pkg::KEY_W-1:0]     key,
    input  ubwt_pkg::ubwt_tbl_wr_t         wr,
    output ubwt_pkg::ubwt_scan_res_t       res
);
    import ubwt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [COST_W-1:0] cost_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               scanning_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic [COST_W-1:0]  cost_rd_reg;
    ubwt_scan_res_t     res_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               entry_valid;

    assign rd_addr     = rd_cnt_reg[IDX_W-1:0];
    assign wr_addr     = wr.slot[IDX_W-1:0];
    assign entry_valid = valid_reg[cmp_idx_reg];

    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[rd_addr];
        cost_rd_reg <= cost_mem[rd_addr];
        if (wr.set)
        begin
            key_mem[wr_addr]  <= wr.key;
            cost_mem[wr_addr] <= wr.cost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_cnt_reg   <= '0;
            scanning_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            res_reg      <= '0;
        end
        else
        begin
            if (wr.set)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr.clear)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end

            if (start)
            begin
                rd_cnt_reg   <= '0;
                scanning_reg <= 1'b1;
                cmp_vld_reg  <= 1'b0;
                res_reg      <= '0;
            end
            else if (scanning_reg)
            begin
                if (rd_cnt_reg < CNT_W'(ENTRIES))
                begin
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= rd_addr;
                    rd_cnt_reg  <= rd_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_reg <= 1'b0;
                end

                if (cmp_vld_reg)
                begin
                    if (entry_valid && key_rd_reg == key && !res_reg.hit)
                    begin
                        res_reg.hit      <= 1'b1;
                        res_reg.hit_slot <= SLOT_W_MAX'(cmp_idx_reg);
                        res_reg.hit_cost <= cost_rd_reg;
                    end
                    if (!entry_valid && !res_reg.vacant)
                    begin
                        res_reg.vacant      <= 1'b1;
                        res_reg.vacant_slot <= SLOT_W_MAX'(cmp_idx_reg);
                    end
                    if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        scanning_reg <= 1'b0;
                        res_reg.done <= 1'b1;
                    end
                end
            end
        end
    end

    assign res = res_reg;

endmodule

### rtl/usb_endpoint_bandwidth_table_top.sv
`timescale 1ns / 1ps
// A register command with a non-zero packet size returns its word once the bit-serial divide
// and multiply of 17 steps each and the slot scan have finished.
// Every other command returns its word once the slot scan that reads one table entry per
// cycle has finished; one word is in work at a time, so a new word is taken in the cycle
// after the previous result is registered.
// Reset empties the table through its valid bits and clears the reserved and total bandwidth.

module usb_endpoint_bandwidth_table_top
#(
    parameter int TABLE_ENTRIES = ubwt_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ubwt_pkg::BW_W-1:0]    cfg_wdata,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  ubwt_pkg::cmd_word_t          cmd_word,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output ubwt_pkg::rsp_word_t          rsp_word
);
    import ubwt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t                state_reg;
    cmd_word_t             item_reg;
    logic                  need_cost_reg;
    logic [BW_W-1:0]       total_reg;
    logic [BW_W-1:0]       reserved_reg;
    logic [BW_W-1:0]       free_reg;
    logic [2:0]            status_reg;
    logic [COST_W-1:0]     cost_reg;
    logic [SLOT_W_MAX-1:0] slot_reg;
    logic                  rsp_valid_reg;
    rsp_word_t             rsp_reg;

    logic [2:0]            status_next;
    logic [COST_W-1:0]     cost_next;
    logic [SLOT_W_MAX-1:0] slot_next;
    logic [BW_W-1:0]       reserved_next;

    logic                  accept;
    logic                  start_cost;
    logic [KEY_W-1:0]      item_key;
    logic [BW_W-1:0]       free_comb;
    logic [COST_W-1:0]     unit_cost;
    logic                  cost_done;
    ubwt_tbl_wr_t          tbl_wr;
    ubwt_scan_res_t        scan_res;

    assign accept     = cmd_valid && !cmd_stall;
    assign cmd_stall  = (state_reg != S_IDLE);
    assign start_cost = accept && cmd_word.command == CMD_REGISTER
                        && cmd_word.packet_size_max != '0;
    assign item_key   = {item_reg.device_address, item_reg.endpoint_number,
                         item_reg.transfer_direction};
    assign free_comb  = (total_reg > reserved_reg) ? total_reg - reserved_reg : '0;

    ubwt_cost u_cost
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start_cost),
        .bus_speed       (cmd_word.bus_speed),
        .transfer_kind   (cmd_word.transfer_kind),
        .packet_size_max (cmd_word.packet_size_max),
        .transfer_bytes  (cmd_word.transfer_bytes),
        .cost            (unit_cost),
        .done            (cost_done)
    );

    ubwt_scan #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (item_key),
        .wr    (tbl_wr),
        .res   (scan_res)
    );

    always_comb
    begin
        status_next   = ST_NOTFOUND;
        cost_next     = '0;
        slot_next     = '0;
        reserved_next = reserved_reg;
        tbl_wr        = '0;
        tbl_wr.key    = item_key;
        tbl_wr.cost   = unit_cost;
        if (item_reg.command == CMD_REGISTER)
        begin
            priority if (item_reg.packet_size_max == '0)
            begin
                status_next = ST_ZEROPKT;
            end
            else if (scan_res.hit)
            begin
                status_next = ST_EXISTS;
                cost_next   = unit_cost;
            end
            else if (BW_W'(unit_cost) > free_reg)
            begin
                status_next = ST_NOSPACE;
                cost_next   = unit_cost;
            end
            else if (!scan_res.vacant)
            begin
                status_next = ST_FULL;
                cost_next   = unit_cost;
            end
            else
            begin
                status_next   = ST_OK;
                cost_next     = unit_cost;
                slot_next     = scan_res.vacant_slot;
                reserved_next = reserved_reg + BW_W'(unit_cost);
                tbl_wr.set    = (state_reg == S_DECIDE);
                tbl_wr.slot   = scan_res.vacant_slot;
            end
        end
        else if ((item_reg.command == CMD_UNREGISTER || item_reg.command == CMD_LOOKUP)
                 && scan_res.hit)
        begin
            status_next = ST_OK;
            cost_next   = scan_res.hit_cost;
            slot_next   = scan_res.hit_slot;
            if (item_reg.command == CMD_UNREGISTER)
            begin
                reserved_next = (reserved_reg > BW_W'(scan_res.hit_cost))
                                ? reserved_reg - BW_W'(scan_res.hit_cost) : '0;
                tbl_wr.clear  = (state_reg == S_DECIDE);
                tbl_wr.slot   = scan_res.hit_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            need_cost_reg <= 1'b0;
            total_reg     <= '0;
            reserved_reg  <= '0;
            free_reg      <= '0;
            status_reg    <= ST_OK;
            cost_reg      <= '0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            free_reg <= free_comb;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (rsp_valid_reg && !rsp_stall && state_reg != S_FINISH)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg      <= cmd_word;
                        need_cost_reg <= start_cost;
                        state_reg     <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    if (scan_res.done && (!need_cost_reg || cost_done))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    status_reg   <= status_next;
                    cost_reg     <= cost_next;
                    slot_reg     <= slot_next;
                    reserved_reg <= reserved_next;
                    state_reg    <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_reg.status         <= status_reg;
                        rsp_reg.bandwidth_cost <= cost_reg;
                        rsp_reg.slot_index     <= slot_reg[SLOT_OUT_W-1:0];
                        rsp_reg.free_bandwidth <= free_comb;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    a_reserved_moves_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(reserved_reg) |-> $past(state_reg == S_DECIDE))
        else $error("reserved bandwidth changed outside the decision step");

    a_decide_after_units: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> scan_res.done && (!need_cost_reg || cost_done))
        else $error("decision taken before the scan or the cost unit finished");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside the finish step");

    a_slot_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != ST_OK |-> rsp_word.slot_index == '0)
        else $error("slot index not zero on a failed command");

endmodule

### test/usb_endpoint_bandwidth_table_top_tb.sv
`timescale 1ns / 1ps

module usb_endpoint_bandwidth_table_top_tb;

    import ubwt_pkg::*;

    localparam int         TABLE_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int         KEY_POOL_SIZE    = 48;
    localparam int         PRINT_CAP        = 200;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam logic [1:0] CMD_RESERVED     = 2'd3;
    localparam logic [1:0] SPEED_HIGH       = 2'd2;
    localparam logic [1:0] SPEED_UNUSED     = 2'd3;
    localparam logic [1:0] KIND_CONTROL     = 2'd0;
    localparam logic [1:0] KIND_BULK        = 2'd2;
    localparam logic [1:0] KIND_INTR        = 2'd3;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cfg_we    = 1'b0;
    logic [BW_W-1:0] cfg_wdata = '0;
    logic            cmd_valid = 1'b0;
    logic            cmd_stall;
    cmd_word_t       cmd_word  = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    rsp_word_t       rsp_word;

    cmd_word_t       cmd_pending [$];
    rsp_word_t       rsp_expected [$];
    rsp_word_t       rsp_oldest;

    logic [KEY_W-1:0]  key_pool [KEY_POOL_SIZE];

    logic [TABLE_ENTRIES-1:0] ep_used = '0;
    logic [KEY_W-1:0]         ep_key  [TABLE_ENTRIES];
    logic [31:0]              ep_cost [TABLE_ENTRIES];
    logic [31:0]              bw_reserved = '0;
    logic [31:0]              bw_total    = '0;

    int   send_idle_pct  = 0;
    int   rsp_stall_pct  = 0;
    bit   rsp_hold       = 1'b0;
    event long_hold_go;
    int   mismatch_count = 0;
    int   cmds_accepted  = 0;
    int   rsp_checked    = 0;
    int   status_seen [6];

    usb_endpoint_bandwidth_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] free_bw();
        return (bw_total > bw_reserved) ? bw_total - bw_reserved : 32'd0;
    endfunction

    function automatic rsp_word_t predict_endpoint_op(input cmd_word_t c);
        rsp_word_t        r;
        logic [KEY_W-1:0] k;
        logic [31:0]      packets;
        logic [31:0]      cost;
        logic [31:0]      mps;
        int               hit;
        int               vacant;
        int               i;
        k = {c.device_address, c.endpoint_number, c.transfer_direction};
        hit = -1;
        vacant = -1;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (ep_used[i] && ep_key[i] == k && hit < 0)
                hit = i;
            if (!ep_used[i] && vacant < 0)
                vacant = i;
        end
        r = '0;
        r.status = ST_NOTFOUND;
        if (c.command == CMD_REGISTER)
        begin
            mps = 32'(c.packet_size_max);
            if (mps == 0)
                r.status = ST_ZEROPKT;
            else
            begin
                packets = (32'(c.transfer_bytes) + mps - 32'd1) / mps;
                if (c.bus_speed == SPEED_LOW)
                    cost = packets * (32'(OVERHEAD_STD) + mps) * 32'd8;
                else if (c.bus_speed == SPEED_FULL)
                    cost = packets * (((c.transfer_kind == KIND_ISOCHRONOUS) ?
                           32'(OVERHEAD_ISO) : 32'(OVERHEAD_STD)) + mps);
                else
                    cost = 32'd0;
                r.bandwidth_cost = cost[COST_W-1:0];
                if (hit >= 0)
                    r.status = ST_EXISTS;
                else if (cost > free_bw())
                    r.status = ST_NOSPACE;
                else if (vacant < 0)
                    r.status = ST_FULL;
                else
                begin
                    ep_used[vacant] = 1'b1;
                    ep_key[vacant]  = k;
                    ep_cost[vacant] = cost;
                    bw_reserved     = bw_reserved + cost;
                    r.status        = ST_OK;
                    r.slot_index    = vacant[SLOT_OUT_W-1:0];
                end
            end
        end
        else if ((c.command == CMD_UNREGISTER || c.command == CMD_LOOKUP) && hit >= 0)
        begin
            r.status         = ST_OK;
            r.bandwidth_cost = ep_cost[hit][COST_W-1:0];
            r.slot_index     = hit[SLOT_OUT_W-1:0];
            if (c.command == CMD_UNREGISTER)
            begin
                bw_reserved  = (bw_reserved > ep_cost[hit]) ? bw_reserved - ep_cost[hit] : 32'd0;
                ep_used[hit] = 1'b0;
            end
        end
        r.free_bandwidth = free_bw();
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic cmd_word_t make_cmd(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                           input logic [1:0] speed, input logic [1:0] kind,
                                           input logic [MPS_W-1:0] mps,
                                           input logic [BYTES_W-1:0] bytes);
        cmd_word_t c;
        c = '0;
        c.command = op;
        {c.device_address, c.endpoint_number, c.transfer_direction} = k;
        c.bus_speed       = speed;
        c.transfer_kind   = kind;
        c.packet_size_max = mps;
        c.transfer_bytes  = bytes;
        return c;
    endfunction

    function automatic cmd_word_t random_endpoint_cmd(input int key_span);
        logic [1:0]         op;
        logic [KEY_W-1:0]   k;
        logic [MPS_W-1:0]   mps;
        logic [BYTES_W-1:0] bytes;
        int                 sel;
        sel = $urandom_range(99);
        if (sel < 45)
            op = CMD_REGISTER;
        else if (sel < 70)
            op = CMD_UNREGISTER;
        else if (sel < 93)
            op = CMD_LOOKUP;
        else
            op = CMD_RESERVED;
        if ($urandom_range(9) == 0)
            k = KEY_W'($urandom);
        else
            k = key_pool[$urandom_range(key_span - 1)];
        case ($urandom_range(15))
            0:       mps = '0;
            1:       mps = 10'd1;
            2:       mps = 10'd1023;
            default: mps = MPS_W'($urandom_range(1023, 8));
        endcase
        case ($urandom_range(7))
            0:       bytes = '0;
            1:       bytes = 16'hFFFF;
            2:       bytes = BYTES_W'($urandom);
            default: bytes = BYTES_W'($urandom_range(2048));
        endcase
        return make_cmd(op, k, 2'($urandom_range(3)), 2'($urandom_range(3)), mps, bytes);
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // A new word is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_word  <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                rsp_expected.push_back(predict_endpoint_op(cmd_word));
                cmds_accepted++;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_word  <= cmd_pending.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_checked++;
                if (rsp_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_CAP)
                        $display("%0t: unexpected response, expected none, actual %p",
                                 $time, rsp_word);
                end
                else
                begin
                    rsp_oldest = rsp_expected.pop_front();
                    report_field("status", 32'(rsp_oldest.status), 32'(rsp_word.status));
                    report_field("bandwidth_cost", 32'(rsp_oldest.bandwidth_cost),
                                 32'(rsp_word.bandwidth_cost));
                    report_field("slot_index", 32'(rsp_oldest.slot_index),
                                 32'(rsp_word.slot_index));
                    report_field("free_bandwidth", rsp_oldest.free_bandwidth,
                                 rsp_word.free_bandwidth);
                end
            end
            rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
        end
    end

    always @(long_hold_go)
    begin
        rsp_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rsp_hold = 1'b0;
    end

    task automatic wait_for_drain();
        @(negedge clk);
        while (cmd_pending.size() != 0 || cmd_valid || rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_total_bandwidth(input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        bw_total   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [31:0] total, input int count, input int key_span,
                             input int send_pct, input int stall_pct, input bit long_hold);
        wait_for_drain();
        write_total_bandwidth(total);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        repeat (count)
            cmd_pending.push_back(random_endpoint_cmd(key_span));
        if (long_hold)
            -> long_hold_go;
    endtask

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = KEY_W'($urandom);
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The total bandwidth is still zero from reset here.
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd5, 4'd1, 2'd0}, SPEED_FULL,
                                       KIND_BULK, 10'd64, 16'd512));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd5, 4'd1, 2'd0}, SPEED_FULL,
                                       KIND_BULK, 10'd0, 16'd512));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd127, 4'd15, 2'd3}, SPEED_HIGH,
                                       KIND_INTR, 10'd1023, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd0, 4'd0, 2'd0}, SPEED_UNUSED,
                                       KIND_CONTROL, 10'd1, 16'd0));
        cmd_pending.push_back(make_cmd(CMD_LOOKUP, {7'd127, 4'd15, 2'd3}, 2'd0, 2'd0, '0, '0));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd127, 4'd15, 2'd3}, SPEED_LOW,
                                       KIND_CONTROL, 10'd8, 16'd8));
        cmd_pending.push_back(make_cmd(CMD_UNREGISTER, {7'd5, 4'd1, 2'd0}, 2'd3, 2'd3,
                                       10'h3FF, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_RESERVED, {7'd127, 4'd15, 2'd3}, 2'd0, 2'd0,
                                       '0, '0));
        cmd_pending.push_back(make_cmd(CMD_UNREGISTER, {7'd0, 4'd0, 2'd0}, 2'd0, 2'd0,
                                       '0, '0));
        wait_for_drain();

        write_total_bandwidth(32'hFFFF_FFFF);
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd1, 4'd2, 2'd1}, SPEED_LOW,
                                       KIND_INTR, 10'd1, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd2, 4'd3, 2'd0}, SPEED_FULL,
                                       KIND_ISOCHRONOUS, 10'd1023, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd3, 4'd0, 2'd2}, SPEED_FULL,
                                       KIND_CONTROL, 10'd1023, 16'd1));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd4, 4'd7, 2'd1}, SPEED_FULL,
                                       KIND_INTR, 10'd8, 16'd0));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd64, 4'd8, 2'd2}, SPEED_LOW,
                                       KIND_BULK, 10'd1023, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_LOOKUP, {7'd1, 4'd2, 2'd1}, 2'd0, 2'd0, '0, '0));
        cmd_pending.push_back(make_cmd(CMD_UNREGISTER, {7'd1, 4'd2, 2'd1}, 2'd0, 2'd0,
                                       '0, '0));
        cmd_pending.push_back(make_cmd(CMD_LOOKUP, {7'd1, 4'd2, 2'd1}, 2'd0, 2'd0, '0, '0));
        cmd_pending.push_back(make_cmd(CMD_REGISTER, {7'd42, 4'd9, 2'd3}, SPEED_FULL,
                                       KIND_BULK, 10'd1023, 16'hFFFF));
        cmd_pending.push_back(make_cmd(CMD_LOOKUP, {7'd64, 4'd8, 2'd2}, 2'd0, 2'd0, '0, '0));

        run_phase(32'hFFFF_FFFF, 225, KEY_POOL_SIZE, 0, 0, 1'b0);
        run_phase(32'd60000, 225, 40, 72, 0, 1'b0);
        run_phase($urandom, 225, 40, 0, 72, 1'b0);
        run_phase(32'd3000, 225, 24, 14, 14, 1'b0);
        run_phase(32'd0, 225, 40, 0, 72, 1'b0);
        run_phase(32'd500000, 225, KEY_POOL_SIZE, 0, 0, 1'b1);

        wait_for_drain();
        repeat (2 * TABLE_ENTRIES + 16) @(negedge clk);

        $display("Checked %0d responses to %0d commands over seven bandwidth settings,",
                 rsp_checked, cmds_accepted);
        $display("ok %0d, exists %0d, no bandwidth %0d, full %0d, not found %0d, zero size %0d",
                 status_seen[ST_OK], status_seen[ST_EXISTS], status_seen[ST_NOSPACE],
                 status_seen[ST_FULL], status_seen[ST_NOTFOUND], status_seen[ST_ZEROPKT]);
        if (mismatch_count == 0 && rsp_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
